// ----- src/ptme_pkg.sv -----
// shared types and constants of the page table map engine
// used by the controller, the datapath and the top level
package ptme_pkg;

    localparam int FRAME_COUNT = 64;
    localparam int FW          = $clog2(FRAME_COUNT);
    localparam int NFW         = FW + 1;
    localparam int MAW         = FW + 10;

    localparam logic [2:0] CMD_MAP    = 3'd0;
    localparam logic [2:0] CMD_FORGET = 3'd1;
    localparam logic [2:0] CMD_SHARE  = 3'd2;
    localparam logic [2:0] CMD_FAULT  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [19:0] BASE_RESET = 20'd256;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RD_DIR_VA,
        OP_RD_DIR_TO,
        OP_CHECK,
        OP_W_DIR,
        OP_W_PDE,
        OP_RD_ENT,
        OP_WR_MAP,
        OP_FORGET,
        OP_WR_ZERO,
        OP_CAP_SRC,
        OP_WR_SHARE,
        OP_ALLOC_DATA,
        OP_FILL,
        OP_WR_FAULT,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic wsel;   // 0 walks vaddr, 1 walks target_vaddr
    } ctrl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       oof;
        logic       high;
        logic       fill_last;
        logic       clear_last;
        logic       out_busy;
    } stat_t;

endpackage

// ----- src/ptme_dp.sv -----
// datapath of the page table map engine: frame store, allocator, walk registers
// and result register; driven by ptme_ctrl, uses ptme_pkg
module ptme_dp (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [19:0]      cfg_wr_data,
    input  logic [2:0]       s_command,
    input  logic [31:0]      s_vaddr,
    input  logic [31:0]      s_target_vaddr,
    input  logic [31:0]      s_paddr,
    input  ptme_pkg::ctrl_t  ctrl,
    output ptme_pkg::stat_t  stat,
    input  logic             m_ready,
    output logic             m_valid,
    output logic             m_dirty_bit,
    output logic             m_invalidate,
    output logic [31:0]      m_invalidate_addr,
    output logic [31:0]      m_last_fault,
    output logic [31:0]      m_directory_addr,
    output logic [31:0]      m_fault_frame,
    output logic             m_out_of_frames
);
    import ptme_pkg::*;

    logic [31:0] mem [2**MAW];
    logic [31:0] mem_q_reg;
    logic [MAW-1:0] mem_addr;
    logic        mem_we;
    logic [31:0] mem_wdata;

    logic [19:0]    frame_base_reg;
    logic [NFW-1:0] next_frame_reg;
    logic           dir_made_reg;
    logic [FW-1:0]  dir_frame_reg;
    logic [31:0]    last_fault_reg;
    logic [MAW-1:0] clr_cnt_reg;

    logic [2:0]     cmd_reg;
    logic [31:0]    va_reg, to_reg, pa_reg;
    logic [31:0]    pde_va_reg, src_reg;
    logic [MAW-1:0] ent_reg;
    logic [FW-1:0]  fill_frame_reg;
    logic [9:0]     fill_idx_reg;
    logic           dirty_reg, inval_reg, oof_reg;
    logic [31:0]    inval_addr_reg, fframe_reg;

    logic           m_valid_reg, m_dirty_reg, m_inval_reg, m_oof_reg;
    logic [31:0]    m_inval_addr_reg, m_last_fault_reg, m_dir_addr_reg, m_fframe_reg;

    logic [31:0]    wva;
    logic [FW-1:0]  dir_eff;
    logic [MAW-1:0] slot_addr;
    logic [31:0]    pde_new;
    logic [19:0]    t_diff;
    logic           tm_va, tm_to;
    logic [1:0]     need;
    logic [NFW-1:0] free_frames;

    // walk helpers
    assign wva       = ctrl.wsel ? to_reg : va_reg;
    assign dir_eff   = dir_made_reg ? dir_frame_reg : next_frame_reg[FW-1:0];
    assign slot_addr = {dir_eff, wva[31:22]};
    assign pde_new   = mem_q_reg[0] ? mem_q_reg
                     : {frame_base_reg + 20'(next_frame_reg), 12'h001};
    assign t_diff    = pde_new[31:12] - frame_base_reg;

    // frame count check, q holds the directory entry of target_vaddr
    always_comb begin
        tm_va = !dir_made_reg || !pde_va_reg[0];
        tm_to = !dir_made_reg || !mem_q_reg[0];
        need  = {1'b0, !dir_made_reg};
        if (cmd_reg == CMD_SHARE) begin
            need = need + {1'b0, tm_to};
            need = need + {1'b0, (va_reg[31:22] != to_reg[31:22]) && tm_va};
        end else begin
            need = need + {1'b0, tm_va};
        end
        need = need + {1'b0, cmd_reg == CMD_FAULT};
        free_frames = NFW'(FRAME_COUNT) - next_frame_reg;
    end

    // store port control
    always_comb begin
        mem_addr  = ent_reg;
        mem_we    = 1'b0;
        mem_wdata = '0;
        case (ctrl.op)
            OP_CLEAR: begin
                mem_addr = clr_cnt_reg;
                mem_we   = 1'b1;
            end
            OP_RD_DIR_VA: mem_addr = {dir_eff, va_reg[31:22]};
            OP_RD_DIR_TO: mem_addr = {dir_eff, to_reg[31:22]};
            OP_W_DIR:     mem_addr = slot_addr;
            OP_W_PDE: begin
                mem_addr  = slot_addr;
                mem_we    = !mem_q_reg[0];
                mem_wdata = pde_new;
            end
            OP_WR_MAP: begin
                mem_we    = 1'b1;
                mem_wdata = pa_reg | 32'h1;
            end
            OP_FORGET, OP_WR_ZERO: mem_we = 1'b1;
            OP_WR_SHARE: begin
                mem_we    = 1'b1;
                mem_wdata = {src_reg[31:12], 12'h001};
            end
            OP_FILL: begin
                mem_addr  = {fill_frame_reg, fill_idx_reg};
                mem_we    = 1'b1;
                mem_wdata = {va_reg[31:12], 12'h000} + {20'h0, fill_idx_reg, 2'b00};
            end
            OP_WR_FAULT: begin
                mem_we    = 1'b1;
                mem_wdata = fframe_reg | 32'h1;
            end
            default: ;
        endcase
    end

    // frame store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= BASE_RESET;
            next_frame_reg <= '0;
            dir_made_reg   <= 1'b0;
            dir_frame_reg  <= '0;
            last_fault_reg <= '0;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                frame_base_reg <= cfg_wr_data;
            end
            if (ctrl.op == OP_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctrl.op == OP_W_DIR && !dir_made_reg) begin
                dir_made_reg   <= 1'b1;
                dir_frame_reg  <= next_frame_reg[FW-1:0];
                next_frame_reg <= next_frame_reg + 1'b1;
            end
            if (ctrl.op == OP_W_PDE && !mem_q_reg[0]) begin
                next_frame_reg <= next_frame_reg + 1'b1;
            end
            if (ctrl.op == OP_ALLOC_DATA) begin
                next_frame_reg <= next_frame_reg + 1'b1;
                last_fault_reg <= va_reg;
            end
            if (ctrl.op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and walk registers
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LOAD: begin
                cmd_reg        <= s_command;
                va_reg         <= s_vaddr;
                to_reg         <= s_target_vaddr;
                pa_reg         <= s_paddr;
                dirty_reg      <= 1'b0;
                inval_reg      <= 1'b0;
                inval_addr_reg <= '0;
                fframe_reg     <= '0;
                oof_reg        <= 1'b0;
            end
            OP_RD_DIR_TO: pde_va_reg <= mem_q_reg;
            OP_CHECK: oof_reg <= (cmd_reg <= CMD_FAULT) &&
                                 ({{(NFW-2){1'b0}}, need} > free_frames);
            OP_W_PDE: ent_reg <= {t_diff[FW-1:0], wva[21:12]};
            OP_FORGET: begin
                dirty_reg      <= mem_q_reg[6];
                inval_reg      <= 1'b1;
                inval_addr_reg <= va_reg;
            end
            OP_WR_ZERO: begin
                inval_reg      <= 1'b1;
                inval_addr_reg <= to_reg;
            end
            OP_CAP_SRC: src_reg <= mem_q_reg;
            OP_ALLOC_DATA: begin
                fill_frame_reg <= next_frame_reg[FW-1:0];
                fill_idx_reg   <= '0;
                fframe_reg     <= {frame_base_reg + 20'(next_frame_reg), 12'h000};
            end
            OP_FILL: fill_idx_reg <= fill_idx_reg + 1'b1;
            OP_OUT: begin
                m_dirty_reg      <= dirty_reg;
                m_inval_reg      <= inval_reg;
                m_inval_addr_reg <= inval_addr_reg;
                m_last_fault_reg <= last_fault_reg;
                m_dir_addr_reg   <= dir_made_reg
                                  ? {frame_base_reg + 20'(dir_frame_reg), 12'h000} : '0;
                m_fframe_reg     <= fframe_reg;
                m_oof_reg        <= oof_reg;
            end
            default: ;
        endcase
    end

    // status to the controller
    assign stat.cmd        = cmd_reg;
    assign stat.oof        = oof_reg;
    assign stat.high       = va_reg[31];
    assign stat.fill_last  = (fill_idx_reg == 10'h3FF);
    assign stat.clear_last = (clr_cnt_reg == {MAW{1'b1}});
    assign stat.out_busy   = m_valid_reg && !m_ready;

    assign m_valid           = m_valid_reg;
    assign m_dirty_bit       = m_dirty_reg;
    assign m_invalidate      = m_inval_reg;
    assign m_invalidate_addr = m_inval_addr_reg;
    assign m_last_fault      = m_last_fault_reg;
    assign m_directory_addr  = m_dir_addr_reg;
    assign m_fault_frame     = m_fframe_reg;
    assign m_out_of_frames   = m_oof_reg;

endmodule

// ----- src/ptme_ctrl.sv -----
// controller of the page table map engine: sequences clear, check, walks and writes
// uses ptme_pkg, drives ptme_dp
module ptme_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ptme_pkg::stat_t  stat,
    output ptme_pkg::ctrl_t  ctrl
);
    import ptme_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RDA, S_RDB, S_CHK, S_DISP, S_WDIR, S_WPDE,
        S_MAPWR, S_FRD, S_FWR, S_SZERO, S_SRD, S_SCAP, S_SWR,
        S_FALLOC, S_FILL, S_FAULTWR, S_OUT
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic   wsel_reg, wsel_next;
    op_t    op;

    // next state and command
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        wsel_next  = wsel_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_CLEAR: begin
                op = OP_CLEAR;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = S_RDA;
                end
            end
            S_RDA: begin
                op         = OP_RD_DIR_VA;
                state_next = S_RDB;
            end
            S_RDB: begin
                op         = OP_RD_DIR_TO;
                state_next = S_CHK;
            end
            S_CHK: begin
                op         = OP_CHECK;
                state_next = S_DISP;
            end
            S_DISP: begin
                if (stat.oof) begin
                    state_next = S_OUT;
                end else begin
                    case (stat.cmd)
                        CMD_MAP: begin
                            wsel_next  = 1'b0;
                            ret_next   = S_MAPWR;
                            state_next = S_WDIR;
                        end
                        CMD_FORGET: begin
                            wsel_next  = 1'b0;
                            ret_next   = S_FRD;
                            state_next = S_WDIR;
                        end
                        CMD_SHARE: begin
                            wsel_next  = 1'b1;
                            ret_next   = S_SZERO;
                            state_next = S_WDIR;
                        end
                        CMD_FAULT: state_next = S_FALLOC;
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_WDIR: begin
                op         = OP_W_DIR;
                state_next = S_WPDE;
            end
            S_WPDE: begin
                op         = OP_W_PDE;
                state_next = ret_reg;
            end
            S_MAPWR: begin
                op         = OP_WR_MAP;
                state_next = S_OUT;
            end
            S_FRD: begin
                op         = OP_RD_ENT;
                state_next = S_FWR;
            end
            S_FWR: begin
                op         = OP_FORGET;
                state_next = S_OUT;
            end
            S_SZERO: begin
                op         = OP_WR_ZERO;
                wsel_next  = 1'b0;
                ret_next   = S_SRD;
                state_next = S_WDIR;
            end
            S_SRD: begin
                op         = OP_RD_ENT;
                state_next = S_SCAP;
            end
            S_SCAP: begin
                op         = OP_CAP_SRC;
                wsel_next  = 1'b1;
                ret_next   = S_SWR;
                state_next = S_WDIR;
            end
            S_SWR: begin
                op         = OP_WR_SHARE;
                state_next = S_OUT;
            end
            S_FALLOC: begin
                op = OP_ALLOC_DATA;
                if (stat.high) begin
                    state_next = S_FILL;
                end else begin
                    wsel_next  = 1'b0;
                    ret_next   = S_FAULTWR;
                    state_next = S_WDIR;
                end
            end
            S_FILL: begin
                op = OP_FILL;
                if (stat.fill_last) begin
                    wsel_next  = 1'b0;
                    ret_next   = S_FAULTWR;
                    state_next = S_WDIR;
                end
            end
            S_FAULTWR: begin
                op         = OP_WR_FAULT;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and walk return registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_OUT;
            wsel_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            wsel_reg  <= wsel_next;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign ctrl.op   = op;
    assign ctrl.wsel = wsel_reg;

endmodule

// ----- src/page_table_map_engine.sv -----
// Page table map engine: two-level page directory and tables in a frame store.
// Input channel s_valid/s_ready carries one command item (map, forget, share,
// page fault, read status); result channel m_valid/m_ready returns one result
// item per command. frame_base is written through cfg_wr_en/cfg_wr_data.
// Every directory and table access is a step through the single-port frame
// store; a page fault in the upper half also fills all 1024 words of the new
// frame before its table entry is written.
// One item is processed at a time; the next is taken once the result is in
// the output register.
// Reset: synchronous active low. After reset the frame store is cleared one
// word per cycle (65536 words) while s_ready stays low; configuration writes
// are taken during that pass.
// A stalled receiver holds the result in the output register; the block
// finishes the next item and waits to hand it over until m_ready frees it.
module page_table_map_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [19:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [31:0] s_vaddr,
    input  logic [31:0] s_target_vaddr,
    input  logic [31:0] s_paddr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_dirty_bit,
    output logic        m_invalidate,
    output logic [31:0] m_invalidate_addr,
    output logic [31:0] m_last_fault,
    output logic [31:0] m_directory_addr,
    output logic [31:0] m_fault_frame,
    output logic        m_out_of_frames
);
    import ptme_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // sequencer
    ptme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // store and registers
    ptme_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_command         (s_command),
        .s_vaddr           (s_vaddr),
        .s_target_vaddr    (s_target_vaddr),
        .s_paddr           (s_paddr),
        .ctrl              (ctrl),
        .stat              (stat),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_dirty_bit       (m_dirty_bit),
        .m_invalidate      (m_invalidate),
        .m_invalidate_addr (m_invalidate_addr),
        .m_last_fault      (m_last_fault),
        .m_directory_addr  (m_directory_addr),
        .m_fault_frame     (m_fault_frame),
        .m_out_of_frames   (m_out_of_frames)
    );

endmodule

// ----- src/ptme_checker.sv -----
// port checker of the page table map engine and its bind to the top level
// sees only top-level ports
module ptme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_dirty_bit,
    input logic        m_invalidate,
    input logic [31:0] m_invalidate_addr,
    input logic [31:0] m_fault_frame
);

    // a stalled result item stays valid and keeps its invalidate address
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_invalidate_addr))
        else $error("result item changed while stalled");

    // a dirty report only comes with an invalidate request
    a_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dirty_bit |-> m_invalidate)
        else $error("dirty bit without invalidate");

    // no invalidate address without a request
    a_inval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_invalidate |-> m_invalidate_addr == 32'h0)
        else $error("invalidate address without request");

    // a fault frame excludes an invalidate request
    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fault_frame != 32'h0 |-> !m_invalidate)
        else $error("fault frame with invalidate");

endmodule

bind page_table_map_engine ptme_checker u_ptme_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_dirty_bit       (m_dirty_bit),
    .m_invalidate      (m_invalidate),
    .m_invalidate_addr (m_invalidate_addr),
    .m_fault_frame     (m_fault_frame)
);

// ----- tb/page_table_map_engine_tb.sv -----
// testbench of the page table map engine: directed and random command items
// checked against a predictor of the directory, tables and frame allocator
// depends on ptme_pkg and the page_table_map_engine top level
`timescale 1ns / 100ps

module page_table_map_engine_tb;
    import ptme_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [31:0] PAGE_MASK = 32'hFFFFF000;

    typedef struct packed {
        logic        dirty;
        logic        inval;
        logic [31:0] inval_addr;
        logic [31:0] last_fault;
        logic [31:0] dir_addr;
        logic [31:0] fault_frame;
        logic        oof;
    } walk_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [19:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command = '0;
    logic [31:0] s_vaddr = '0;
    logic [31:0] s_target_vaddr = '0;
    logic [31:0] s_paddr = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_dirty_bit;
    logic        m_invalidate;
    logic [31:0] m_invalidate_addr;
    logic [31:0] m_last_fault;
    logic [31:0] m_directory_addr;
    logic [31:0] m_fault_frame;
    logic        m_out_of_frames;

    page_table_map_engine u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_vaddr(s_vaddr), .s_target_vaddr(s_target_vaddr), .s_paddr(s_paddr),
        .m_valid(m_valid), .m_ready(m_ready), .m_dirty_bit(m_dirty_bit),
        .m_invalidate(m_invalidate), .m_invalidate_addr(m_invalidate_addr),
        .m_last_fault(m_last_fault), .m_directory_addr(m_directory_addr),
        .m_fault_frame(m_fault_frame), .m_out_of_frames(m_out_of_frames)
    );

    // predictor state: frame store copy and allocator
    logic [31:0] pt_mem [0:FRAME_COUNT*1024-1];
    int          next_free;
    logic        dir_made;
    int          dir_frame;
    logic [31:0] fault_addr;
    logic [19:0] base_frame;

    walk_result_t pending_q[$];
    int           errors;
    int           cycles;
    bit           idle_en;
    logic [9:0]   dir_pool [0:5];

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] frame_phys(int k);
        logic [31:0] f;
        f = {12'd0, base_frame} + k;
        return f << 12;
    endfunction

    function automatic int dir_slot(logic [31:0] va);
        return dir_frame * 1024 + va[31:22];
    endfunction

    function automatic bit table_absent(logic [31:0] va);
        if (!dir_made) return 1'b1;
        return !pt_mem[dir_slot(va)][0];
    endfunction

    // walk to the table entry of va, allocating directory and table
    function automatic int entry_index(logic [31:0] va);
        int          slot;
        logic [19:0] d;
        if (!dir_made) begin
            dir_made  = 1'b1;
            dir_frame = next_free;
            next_free++;
        end
        slot = dir_slot(va);
        if (!pt_mem[slot][0]) begin
            pt_mem[slot] = (frame_phys(next_free) & PAGE_MASK) | 32'h1;
            next_free++;
        end
        d = pt_mem[slot][31:12] - base_frame;
        return int'(d[FW-1:0]) * 1024 + va[21:12];
    endfunction

    function automatic walk_result_t predict_walk(logic [2:0] cmd, logic [31:0] va,
                                                  logic [31:0] to, logic [31:0] pa);
        walk_result_t r;
        int           need, e, k;
        logic [31:0]  src;
        r = '0;
        need = 0;
        if (cmd <= CMD_FAULT) begin
            if (!dir_made) need++;
            if (cmd == CMD_SHARE) begin
                if (table_absent(to)) need++;
                if (va[31:22] != to[31:22] && table_absent(va)) need++;
            end else if (table_absent(va)) begin
                need++;
            end
            if (cmd == CMD_FAULT) need++;
            if (need > FRAME_COUNT - next_free) begin
                r.oof = 1'b1;
                cmd = CMD_READ;
            end
        end
        case (cmd)
            CMD_MAP: begin
                pt_mem[entry_index(va)] = pa | 32'h1;
            end
            CMD_FORGET: begin
                e = entry_index(va);
                r.dirty = pt_mem[e][6];
                pt_mem[e] = '0;
                r.inval = 1'b1;
                r.inval_addr = va;
            end
            CMD_SHARE: begin
                pt_mem[entry_index(to)] = '0;
                r.inval = 1'b1;
                r.inval_addr = to;
                src = pt_mem[entry_index(va)] & PAGE_MASK;
                pt_mem[entry_index(to)] = src | 32'h1;
            end
            CMD_FAULT: begin
                k = next_free;
                next_free++;
                fault_addr = va;
                r.fault_frame = frame_phys(k);
                if (va[31]) begin
                    for (int i = 0; i < 1024; i++)
                        pt_mem[k*1024 + i] = (va & PAGE_MASK) + 32'(4 * i);
                end
                pt_mem[entry_index(va)] = r.fault_frame | 32'h1;
            end
            default: ;
        endcase
        r.last_fault = fault_addr;
        r.dir_addr = dir_made ? frame_phys(dir_frame) : 32'd0;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    // result side: random stalls and field checks
    always @(posedge aclk) begin
        walk_result_t w;
        m_ready <= !idle_en || ($urandom_range(99) >= 22);
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected item", 32'd0, 32'd0);
            end else begin
                w = pending_q.pop_front();
                if (m_dirty_bit !== w.dirty)
                    report_mismatch("dirty_bit", 32'(m_dirty_bit), 32'(w.dirty));
                if (m_invalidate !== w.inval)
                    report_mismatch("invalidate", 32'(m_invalidate), 32'(w.inval));
                if (m_invalidate_addr !== w.inval_addr)
                    report_mismatch("invalidate_addr", m_invalidate_addr, w.inval_addr);
                if (m_last_fault !== w.last_fault)
                    report_mismatch("last_fault", m_last_fault, w.last_fault);
                if (m_directory_addr !== w.dir_addr)
                    report_mismatch("directory_addr", m_directory_addr, w.dir_addr);
                if (m_fault_frame !== w.fault_frame)
                    report_mismatch("fault_frame", m_fault_frame, w.fault_frame);
                if (m_out_of_frames !== w.oof)
                    report_mismatch("out_of_frames", 32'(m_out_of_frames), 32'(w.oof));
            end
        end
    end

    // send one command item; valid stays high across back-to-back items
    task automatic send_cmd(logic [2:0] cmd, logic [31:0] va, logic [31:0] to,
                            logic [31:0] pa);
        if (idle_en && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 50);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_vaddr        <= va;
        s_target_vaddr <= to;
        s_paddr        <= pa;
        pending_q.push_back(predict_walk(cmd, va, to, pa));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_base(logic [19:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        base_frame = v;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pool_addr();
        logic [31:0] a;
        a = $urandom;
        a[31:22] = dir_pool[$urandom_range(5)];
        a[21:12] = 10'($urandom_range(15));
        return a;
    endfunction

    // extremes of every command with the base at its top value
    task automatic test_directed_top_base();
        write_base(20'hFFFFF);
        send_cmd(CMD_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_cmd(CMD_MAP, 32'h0, 32'h0, 32'hFFFFFFFF);
        send_cmd(CMD_FORGET, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_FORGET, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_MAP, 32'hFFFFFFFF, 32'h0, 32'h12345040);
        send_cmd(CMD_SHARE, 32'hFFFFFFFF, 32'hFFFFF123, 32'h0);
        send_cmd(CMD_MAP, 32'h00401000, 32'h0, 32'hABCDE000);
        send_cmd(CMD_SHARE, 32'h00401000, 32'hFFC02000, 32'h0);
        send_cmd(CMD_SHARE, 32'h00800000, 32'h00C00000, 32'h0);
        send_cmd(CMD_FAULT, 32'h7FFFFFFF, 32'h0, 32'h0);
        send_cmd(CMD_FAULT, 32'h80000000, 32'h0, 32'h0);
        send_cmd(CMD_FORGET, 32'h80000000, 32'h0, 32'h0);
        send_cmd(3'd5, 32'h1, 32'h2, 32'h3);
        send_cmd(3'd6, 32'h0, 32'h0, 32'h0);
        send_cmd(3'd7, 32'hFFFFFFFF, 32'h0, 32'h0);
        drain_results();
    endtask

    // base moved after allocation: existing tables are found through the new base
    task automatic test_moved_base();
        write_base(20'h0);
        send_cmd(CMD_READ, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_MAP, 32'hFFFFF000, 32'h0, 32'h00000040);
        send_cmd(CMD_FORGET, 32'hFFFFF000, 32'h0, 32'h0);
        send_cmd(CMD_SHARE, 32'h00401000, 32'h00402000, 32'h0);
        send_cmd(CMD_FAULT, 32'hFFFFFFFF, 32'h0, 32'h0);
        drain_results();
        write_base(BASE_RESET);
    endtask

    task automatic random_phase(int n);
        logic [2:0]  cmd;
        logic [31:0] va, to, pa;
        int          pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 30) cmd = CMD_MAP;
            else if (pick < 50) cmd = CMD_FORGET;
            else if (pick < 75) cmd = CMD_SHARE;
            else if (pick < 83) cmd = CMD_FAULT;
            else cmd = 3'($urandom_range(7));
            if ($urandom_range(99) < 85) begin
                va = pool_addr();
                to = pool_addr();
            end else begin
                va = $urandom;
                to = $urandom;
            end
            pa = $urandom;
            send_cmd(cmd, va, to, pa);
        end
        drain_results();
    endtask

    task automatic test_random_mix();
        idle_en = 1'b1;
        random_phase(250);
        write_base(20'($urandom));
        idle_en = 1'b0;
        random_phase(250);
        idle_en = 1'b1;
        write_base(20'($urandom));
        random_phase(250);
        write_base(20'hFFFFF);
        random_phase(150);
        write_base(20'h0);
        random_phase(130);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        idle_en = 1'b1;
        next_free = 0;
        dir_made = 1'b0;
        dir_frame = 0;
        fault_addr = '0;
        base_frame = BASE_RESET;
        foreach (pt_mem[i]) pt_mem[i] = '0;
        dir_pool[0] = 10'h000;
        dir_pool[1] = 10'h3FF;
        for (int i = 2; i < 6; i++) dir_pool[i] = 10'($urandom);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_top_base();
        test_moved_base();
        test_random_mix();
        drain_results();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
